@@ rtl/zbcs_pkg.sv @@
package zbcs_pkg;

  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 80;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned DivW    = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN       = 3'd0,
    REG_BIAS_SETTLE = 3'd1,
    REG_ZERO_SETTLE = 3'd2,
    REG_TOL        = 3'd3,
    REG_MAX_ITER   = 3'd4,
    REG_NEG_FULL   = 3'd5,
    REG_POS_FULL   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_TICK  = 2'd0,
    F_ZERO  = 2'd1,
    F_BIAS  = 2'd2,
    F_ABORT = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_STARTED = 3'd1,
    ST_REFUSED = 3'd2,
    ST_ZERO    = 3'd3,
    ST_BIAS    = 3'd4,
    ST_ABORT   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_ZERO = 2'd1,
    K_BIAS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STP_RELAY  = 3'd0,
    STP_SETTLE = 3'd1,
    STP_MEAS   = 3'd2,
    STP_BSTEP  = 3'd3
  } step_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DLD,
    S_DIV,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic    in_load;
    logic    clr_iter;
    logic    start_bias;
    logic    restore;
    logic    load_start;
    logic    load_meas;
    logic    bisect;
    logic    store_bias;
    logic    div_start;
    logic    out_wr;
    logic    zsel;
    status_e status;
    logic    busy;
    logic    short_on;
    logic    res_on;
  } zbcs_cmd_t;

  typedef struct packed {
    logic bset_ok;
    logic zset_ok;
    logic stop;
    logic div_done;
    logic out_free;
  } zbcs_stat_t;

endpackage

@@ rtl/zbcs_div.sv @@
module zbcs_div import zbcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivW-1:0]   num_i,
  input  logic [CfgW-1:0]   den_i,
  output logic              done_o,
  output logic [DivW-1:0]   quo_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [CfgW-1:0] rem_q, rem_d;
  logic [CfgW:0]   trial;
  logic            qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[DivW-1]};
    qbit   = (trial >= {1'b0, den_i});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      quo_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], qbit};
      rem_d = qbit ? CfgW'(trial - {1'b0, den_i}) : trial[CfgW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = !busy_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/zbcs_dp.sv @@
module zbcs_dp import zbcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  zbcs_cmd_t            cmd_i,
  output zbcs_stat_t           stat_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic [31:0]          now_i,
  input  logic signed [39:0]   meas_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [OutDataW-1:0]  m_tdata_o,
  output logic [2:0]           m_tuser_o
);

  logic [23:0] gain_q;
  logic [15:0] bset_q, zset_q;
  logic [19:0] tol_q;
  logic [7:0]  maxit_q;
  logic [22:0] negf_q, posf_q;

  logic [31:0]        now_q;
  logic signed [39:0] meas_q;
  logic [31:0]        start_q, start_d;
  logic [7:0]         iter_q, iter_d;
  logic signed [39:0] last_q, last_d;
  logic [39:0]        mag_q, mag_d;
  logic signed [23:0] lo_q, lo_d, hi_q, hi_d, servo_q, servo_d, bcal_q, bcal_d;
  logic [43:0]        prod_q;

  logic                ovalid_q;
  logic [OutDataW-1:0] odata_q;
  logic [2:0]          ouser_q;

  logic [23:0]        gain_eff;
  logic [31:0]        elapsed;
  logic signed [24:0] width;
  logic               in_tol;
  logic               meas_pos;
  logic signed [23:0] nlo, nhi, slo, shi;
  logic [39:0]        meas_mag;
  logic               div_done;
  logic [DivW-1:0]    quo;
  logic [DivW-1:0]    div_num;
  logic [39:0]        qsat;
  logic signed [39:0] zval;
  logic signed [23:0] leak;

  function automatic logic signed [23:0] mid24(input logic signed [23:0] a,
                                               input logic signed [23:0] b);
    logic signed [24:0] s;
    s = {a[23], a} + {b[23], b};
    return s[24:1];
  endfunction

  assign gain_eff = (gain_q == '0) ? 24'd1 : gain_q;
  assign elapsed  = now_q - start_q;
  assign width    = {hi_q[23], hi_q} - {lo_q[23], lo_q};
  assign in_tol   = {mag_q, 8'b0} < {4'b0, prod_q};
  assign meas_pos = !last_q[39] && (last_q != '0);
  assign meas_mag = meas_q[39] ? (~meas_q + 40'd1) : meas_q;

  assign stat_o.bset_ok  = elapsed >= {16'b0, bset_q};
  assign stat_o.zset_ok  = elapsed >= {16'b0, zset_q};
  assign stat_o.stop     = in_tol || (iter_q >= maxit_q) || (width < 25'sd5);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !ovalid_q || m_tready_i;

  assign nlo = meas_pos ? lo_q : servo_q;
  assign nhi = meas_pos ? servo_q : hi_q;
  assign slo = 24'(24'd0 - {1'b0, negf_q});
  assign shi = {1'b0, posf_q};

  always_comb begin
    start_d = start_q;
    iter_d  = iter_q;
    last_d  = last_q;
    mag_d   = mag_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    servo_d = servo_q;
    bcal_d  = bcal_q;
    if (cmd_i.clr_iter) iter_d = '0;
    if (cmd_i.start_bias) begin
      lo_d    = slo;
      hi_d    = shi;
      servo_d = mid24(slo, shi);
    end
    if (cmd_i.restore) servo_d = bcal_q;
    if (cmd_i.load_start) start_d = now_q;
    if (cmd_i.load_meas) begin
      last_d = meas_q;
      mag_d  = meas_mag;
    end
    if (cmd_i.store_bias) bcal_d = servo_q;
    if (cmd_i.bisect) begin
      lo_d    = nlo;
      hi_d    = nhi;
      servo_d = mid24(nlo, nhi);
      if (iter_q != 8'hFF) iter_d = iter_q + 8'd1;
      start_d = now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 24'd256;
      bset_q  <= 16'd5000;
      zset_q  <= 16'd500;
      tol_q   <= 20'd10;
      maxit_q <= 8'd30;
      negf_q  <= 23'd100000;
      posf_q  <= 23'd100000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN:        gain_q  <= cfg_data_i;
        REG_BIAS_SETTLE: bset_q  <= cfg_data_i[15:0];
        REG_ZERO_SETTLE: zset_q  <= cfg_data_i[15:0];
        REG_TOL:         tol_q   <= cfg_data_i[19:0];
        REG_MAX_ITER:    maxit_q <= cfg_data_i[7:0];
        REG_NEG_FULL:    negf_q  <= cfg_data_i[22:0];
        REG_POS_FULL:    posf_q  <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      iter_q  <= '0;
      last_q  <= '0;
      mag_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      servo_q <= '0;
      bcal_q  <= '0;
    end else begin
      start_q <= start_d;
      iter_q  <= iter_d;
      last_q  <= last_d;
      mag_q   <= mag_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      servo_q <= servo_d;
      bcal_q  <= bcal_d;
    end
  end

  // tolerance threshold, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    prod_q <= tol_q * gain_eff;
    if (cmd_i.in_load) begin
      now_q  <= now_i;
      meas_q <= meas_i;
    end
  end

  // rounded quotient: (|meas| * 256 + gain / 2) / gain
  assign div_num = {mag_q, 8'b0} + {25'b0, gain_eff[23:1]};

  zbcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (gain_eff),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    if (last_q[39]) begin
      qsat = (quo > DivW'(40'h80_0000_0000)) ? 40'h80_0000_0000 : quo[39:0];
      zval = 40'(40'd0 - qsat);
    end else begin
      qsat = (quo > DivW'(40'h7F_FFFF_FFFF)) ? 40'h7F_FFFF_FFFF : quo[39:0];
      zval = qsat;
    end
    if (!cmd_i.zsel) zval = '0;
  end

  assign leak = (bcal_q == 24'sh80_0000) ? 24'sh7F_FFFF : 24'(24'sd0 - bcal_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_wr) begin
      ovalid_q <= 1'b1;
    end else if (m_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_wr) begin
      odata_q <= {5'b0, iter_q, leak, bcal_q, zval, servo_q,
                  cmd_i.res_on, cmd_i.short_on, cmd_i.busy};
      ouser_q <= cmd_i.status;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;
  assign m_tuser_o  = ouser_q;

endmodule

@@ rtl/zbcs_ctrl.sv @@
module zbcs_ctrl import zbcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic       relays_i,
  input  logic       done_i,
  input  zbcs_stat_t stat_i,
  output zbcs_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  kind_e       kind_q, kind_d;
  step_e       step_q, step_d;
  status_e     status_q, status_d;
  logic        short_q, short_d;
  logic        res_q, res_d;
  logic [1:0]  func_q;
  logic        relays_q, done_q;
  logic        zstore;

  // zero store needs the divider before the result is written
  always_comb begin
    zstore = (func_q == F_TICK) && (kind_q == K_ZERO) &&
             (step_q == STP_MEAS) && done_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EVAL;
      S_EVAL: state_d = zstore ? S_DLD : S_OUT;
      S_DLD:  state_d = S_DIV;
      S_DIV:  if (stat_i.div_done) state_d = S_OUT;
      S_OUT:  if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    kind_d   = kind_q;
    step_d   = step_q;
    status_d = status_q;
    short_d  = short_q;
    res_d    = res_q;

    cmd_o.in_load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_DLD);
    cmd_o.out_wr   = (state_q == S_OUT) && stat_i.out_free;
    cmd_o.zsel     = (status_q == ST_ZERO);
    cmd_o.status   = status_q;
    cmd_o.busy     = (kind_q != K_NONE);
    cmd_o.short_on = short_q;
    cmd_o.res_on   = res_q;

    if (state_q == S_EVAL) begin
      status_d = ST_NONE;
      unique case (func_q)
        F_ZERO, F_BIAS: begin
          if (kind_q != K_NONE) begin
            status_d = ST_REFUSED;
          end else begin
            kind_d         = (func_q == F_ZERO) ? K_ZERO : K_BIAS;
            step_d         = STP_RELAY;
            cmd_o.clr_iter = 1'b1;
            status_d       = ST_STARTED;
            short_d        = (func_q == F_ZERO);
            res_d          = (func_q == F_BIAS);
            cmd_o.start_bias = (func_q == F_BIAS);
          end
        end
        F_ABORT: begin
          if (kind_q != K_NONE) begin
            kind_d        = K_NONE;
            short_d       = 1'b0;
            res_d         = 1'b0;
            cmd_o.restore = 1'b1;
            status_d      = ST_ABORT;
          end
        end
        default: begin
          if (kind_q != K_NONE) begin
            unique case (step_q)
              STP_RELAY: begin
                if (!relays_q) begin
                  cmd_o.load_start = 1'b1;
                  step_d           = STP_SETTLE;
                end
              end
              STP_SETTLE: begin
                if ((kind_q == K_BIAS) ? stat_i.bset_ok : stat_i.zset_ok) begin
                  step_d = STP_MEAS;
                end
              end
              STP_MEAS: begin
                if (done_q) begin
                  cmd_o.load_meas = 1'b1;
                  if (kind_q == K_ZERO) begin
                    kind_d   = K_NONE;
                    short_d  = 1'b0;
                    res_d    = 1'b0;
                    status_d = ST_ZERO;
                  end else begin
                    step_d = STP_BSTEP;
                  end
                end
              end
              STP_BSTEP: begin
                if (stat_i.stop) begin
                  cmd_o.store_bias = 1'b1;
                  kind_d           = K_NONE;
                  short_d          = 1'b0;
                  res_d            = 1'b0;
                  status_d         = ST_BIAS;
                end else begin
                  cmd_o.bisect = 1'b1;
                  step_d       = STP_SETTLE;
                end
              end
              default: step_d = STP_RELAY;
            endcase
          end
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= K_NONE;
      step_q   <= STP_RELAY;
      status_q <= ST_NONE;
      short_q  <= 1'b0;
      res_q    <= 1'b0;
      func_q   <= F_TICK;
      relays_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      step_q   <= step_d;
      status_q <= status_d;
      short_q  <= short_d;
      res_q    <= res_d;
      if (cmd_o.in_load) begin
        func_q   <= func_i;
        relays_q <= relays_i;
        done_q   <= done_i;
      end
    end
  end

endmodule

@@ rtl/zero_and_bias_cal_sequencer_top.sv @@
// Calibration sequencer for zero and bias-null runs. Each request on the slave
// stream (tick, start zero, start bias, abort) yields exactly one result on the
// master stream, held in an output register so the next request can be taken
// while it waits. A request is accepted in S_IDLE, evaluated in S_EVAL and
// written to the output register in S_OUT, which waits while that register
// is still full; the tick ending a zero run first runs the 48-step bit-serial
// divider for measurement/gain. Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i and take effect at once.
module zero_and_bias_cal_sequencer_top import zbcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // now_ms[31:0], relays_moving[32], meas_done[33], meas_nv[73:34], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // func[1:0]
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // busy_res[0], short_relay[1], cal_res_relay[2], bias_setpoint[26:3],
  // zero_value_nv[66:27], bias_cal_value[90:67], leak_current[114:91],
  // iteration[122:115], zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]          m_axis_tuser_o
);

  zbcs_cmd_t  cmd;
  zbcs_stat_t stat;

  zbcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .func_i     (s_axis_tuser_i),
    .relays_i   (s_axis_tdata_i[32]),
    .done_i     (s_axis_tdata_i[33]),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  zbcs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .now_i      (s_axis_tdata_i[31:0]),
    .meas_i     (s_axis_tdata_i[73:34]),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule
